/* rtl/rlrw_pkg.sv */
package rlrw_pkg;

    localparam int DEFAULT_VOICE_COUNT = 256;
    localparam int SR_W      = 20;
    localparam int QUOT_BITS = 29;
    localparam int CNT_W     = $clog2(QUOT_BITS + 1);

    localparam logic [SR_W-1:0]      DEFAULT_SR = 20'd44100;
    localparam logic [31:0]          LCG_MUL    = 32'd1664525;
    localparam logic [31:0]          LCG_INC    = 32'd1013904223;
    localparam logic [QUOT_BITS-1:0] STEP_MAX   = 29'd375809638;
    localparam logic [16:0]          AMP_ONE    = 17'd65536;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_PREP,
        ST_DIV,
        ST_MUL1,
        ST_WALK,
        ST_MUL2,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [31:0] seed;
        logic [31:0] pos;
        logic [31:0] last;
    } row_t;

    typedef struct packed {
        logic in_ready;
        logic rd;
        logic prep;
        logic div_step;
        logic mul1;
        logic walk;
        logic mul2;
        logic wr_init;
        logic res_zero;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_done;
        logic accepted;
        logic handle_ok;
        logic is_init;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

/* rtl/rlrw_if.sv */
interface rlrw_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [8:0]  voice_handle;
    logic [31:0] rate_q8;
    logic [16:0] amplitude_q16;
    logic [31:0] seed_value;

    modport source (output valid, action, voice_handle, rate_q8, amplitude_q16, seed_value,
                    input ready);
    modport sink   (input valid, action, voice_handle, rate_q8, amplitude_q16, seed_value,
                    output ready);
endinterface

interface rlrw_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] walk_sample;
    logic               handle_ok;

    modport source (output valid, walk_sample, handle_ok, input ready);
    modport sink   (input valid, walk_sample, handle_ok, output ready);
endinterface

/* rtl/reflecting_lcg_random_walk.sv */
// Sample item: after acceptance it passes through CHECK, PREP, the one-bit-per-cycle
// step divider, MUL1, WALK, MUL2 and FIN; the next item waits until the result is loaded.
// Init items and items with an invalid handle skip the divider and go from CHECK to FIN.
// Asynchronous active-low reset; afterwards a clearing pass writes every voice back to its
// reset values, during which no item is accepted.
// Configuration writes are taken at any time.
module reflecting_lcg_random_walk
    import rlrw_pkg::*;
#(
    parameter int VOICE_COUNT = DEFAULT_VOICE_COUNT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [SR_W-1:0] cfg_wdata,
    rlrw_in_if.sink         in_ch,
    rlrw_out_if.source      out_ch
);

    cmd_t ctl_cmd;
    cmd_t dp_cmd;
    sts_t sts;

    rlrw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (ctl_cmd)
    );

    always_comb
    begin
        dp_cmd = ctl_cmd;
    end

    rlrw_dp #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (dp_cmd),
        .sts       (sts)
    );

endmodule

/* rtl/rlrw_ctrl.sv */
module rlrw_ctrl
    import rlrw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // sequence one item through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.accepted)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                priority if (!sts.handle_ok)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = ST_FIN;
                end
                else if (sts.is_init)
                begin
                    cmd.res_zero = 1'b1;
                    cmd.wr_init  = 1'b1;
                    state_next   = ST_FIN;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                cmd.walk   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

/* rtl/rlrw_dp.sv */
module rlrw_dp
    import rlrw_pkg::*;
#(
    parameter int VOICE_COUNT = DEFAULT_VOICE_COUNT
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [SR_W-1:0] cfg_wdata,
    rlrw_in_if.sink         in_ch,
    rlrw_out_if.source      out_ch,
    input  cmd_t            cmd,
    output sts_t            sts
);

    localparam int AW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int HW = (AW > 9) ? AW : 9;
    localparam logic signed [33:0] ONE_Q30 = 34'sd1073741824;
    localparam logic signed [33:0] TWO_Q30 = 34'sd2147483648;

    row_t mem [VOICE_COUNT];
    row_t mem_q;

    logic [SR_W-1:0]      sr_reg;
    logic                 action_reg;
    logic [8:0]           handle_reg;
    logic [31:0]          rate_reg;
    logic [16:0]          amp_reg;
    logic [31:0]          seedv_reg;
    logic [AW-1:0]        clr_cnt_reg;
    logic                 clr_done_reg;
    logic [31:0]          seed_reg;
    logic [31:0]          pos_reg;
    logic                 sat_reg;
    logic [24:0]          den_reg;
    logic [24:0]          rem_reg;
    logic [QUOT_BITS-1:0] numlo_reg;
    logic [QUOT_BITS-1:0] q_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic signed [61:0]   prod_reg;
    logic [31:0]          x_reg;
    logic [31:0]          res_reg;
    logic                 ok_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_sample_reg;
    logic                 out_ok_reg;

    logic                 accept;
    logic [HW-1:0]        hext;
    logic [AW-1:0]        idx;
    logic                 hok;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    row_t                 wr_row;
    logic [SR_W-1:0]      sr_eff;
    logic [56:0]          num;
    logic                 changed;
    logic [31:0]          seed_eff;
    logic [25:0]          trial;
    logic [QUOT_BITS-1:0] step;
    logic signed [31:0]   bip;
    logic signed [33:0]   sum;
    logic signed [33:0]   xw;
    logic [16:0]          amp_sat;
    logic signed [49:0]   mres;

    assign accept       = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = cmd.in_ready;

    // decode the handle
    assign hext = HW'(handle_reg);
    assign idx  = AW'(hext - HW'(1));
    assign hok  = (handle_reg != 9'd0) && (32'(handle_reg) <= 32'(VOICE_COUNT));

    assign sts.clr_done  = clr_done_reg;
    assign sts.accepted  = accept;
    assign sts.handle_ok = hok;
    assign sts.is_init   = action_reg;
    assign sts.div_last  = (cnt_reg == CNT_W'(1));
    assign sts.out_free  = !out_valid_reg || out_ch.ready;

    // hold the sample rate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sr_reg <= DEFAULT_SR;
        else if (cfg_we)
            sr_reg <= cfg_wdata;
    end

    // capture the accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= in_ch.action;
            handle_reg <= in_ch.voice_handle;
            rate_reg   <= in_ch.rate_q8;
            amp_reg    <= in_ch.amplitude_q16;
            seedv_reg  <= in_ch.seed_value;
        end
    end

    // sweep the voice store to its reset values after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            if (clr_cnt_reg == AW'(VOICE_COUNT - 1))
                clr_done_reg <= 1'b1;
            else
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // select the store write
    always_comb
    begin
        wr_en   = !clr_done_reg || cmd.wr_init || cmd.mul2;
        wr_addr = clr_done_reg ? idx : clr_cnt_reg;
        if (cmd.mul2 && clr_done_reg)
            wr_row = '{seed: seed_reg, pos: x_reg, last: seedv_reg};
        else
            wr_row = '{seed: 32'd1, pos: 32'd0, last: 32'd1};
    end

    // voice store
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_row;
        if (cmd.rd)
            mem_q <= mem[idx];
    end

    // reseed, advance the generator, set up the division, reflect at the bounds and scale by amplitude
    always_comb
    begin
        sr_eff   = (sr_reg == '0) ? DEFAULT_SR : sr_reg;
        num      = (57'(rate_reg) * 57'd7) << 22;
        changed  = (seedv_reg != mem_q.last);
        if (changed)
            seed_eff = (seedv_reg == 32'd0) ? 32'd1 : seedv_reg;
        else
            seed_eff = mem_q.seed;
        trial    = {rem_reg, numlo_reg[QUOT_BITS-1]};
        step     = sat_reg ? STEP_MAX : q_reg;
        bip      = $signed({~seed_reg[31], seed_reg[30:0]});
        sum      = $signed({{2{pos_reg[31]}}, pos_reg})
                 + $signed({{3{prod_reg[61]}}, prod_reg[61:31]});
        priority if (sum > ONE_Q30)
            xw = TWO_Q30 - sum;
        else if (sum < -ONE_Q30)
            xw = -TWO_Q30 - sum;
        else
            xw = sum;
        amp_sat  = (amp_reg > AMP_ONE) ? AMP_ONE : amp_reg;
        mres     = $signed(x_reg) * $signed({1'b0, amp_sat});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            sat_reg   <= (rate_reg >= 32'({sr_eff, 8'd0}));
            den_reg   <= 25'(sr_eff) * 25'd20;
            rem_reg   <= (rate_reg >= 32'({sr_eff, 8'd0})) ? 25'd0 : 25'(num >> QUOT_BITS);
            numlo_reg <= num[QUOT_BITS-1:0];
            q_reg     <= '0;
            cnt_reg   <= CNT_W'(QUOT_BITS);
            seed_reg  <= 32'(seed_eff * LCG_MUL + LCG_INC);
            pos_reg   <= changed ? 32'd0 : mem_q.pos;
        end
        // one quotient bit per cycle
        if (cmd.div_step)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= 25'(trial - {1'b0, den_reg});
                q_reg   <= {q_reg[QUOT_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[24:0];
                q_reg   <= {q_reg[QUOT_BITS-2:0], 1'b0};
            end
            numlo_reg <= numlo_reg << 1;
            cnt_reg   <= cnt_reg - CNT_W'(1);
        end
        if (cmd.mul1)
            prod_reg <= bip * $signed({1'b0, step});
        // step the walk and reflect at the bounds
        if (cmd.walk)
            x_reg <= xw[31:0];
        if (cmd.mul2)
        begin
            res_reg <= mres[47:16];
            ok_reg  <= 1'b1;
        end
        if (cmd.res_zero)
        begin
            res_reg <= 32'd0;
            ok_reg  <= hok;
        end
        if (cmd.out_load)
        begin
            out_sample_reg <= res_reg;
            out_ok_reg     <= ok_reg;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.walk_sample = $signed(out_sample_reg);
    assign out_ch.handle_ok   = out_ok_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> clr_done_reg)
        else $error("item accepted during clearing pass");
    a_bad_handle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.handle_ok |-> out_ch.walk_sample == 32'sd0)
        else $error("invalid handle gave a nonzero sample");
    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul2 |-> ($signed(x_reg) <= 32'sd1073741824 && $signed(x_reg) >= -32'sd1073741824))
        else $error("position outside unit range");
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> cnt_reg != '0)
        else $error("divider stepped past its last bit");
`endif

endmodule

/* tb/rlrw_walk_checker.sv */
`timescale 1ns / 100ps

module rlrw_walk_checker
    import rlrw_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [SR_W-1:0] cfg_wdata,
    rlrw_in_if              in_ch,
    rlrw_out_if             out_ch,
    output int              fail_count,
    output int              pending_count
);

    typedef struct {
        logic signed [31:0] sample;
        logic               ok;
    } walk_result_t;

    localparam int NVOICE = DEFAULT_VOICE_COUNT;

    logic [31:0]  seed_mem [NVOICE];
    logic [31:0]  pos_mem  [NVOICE];
    logic [31:0]  last_mem [NVOICE];
    logic [19:0]  rate_hz;
    walk_result_t sample_queue[$];

    assign pending_count = sample_queue.size();

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Predict the result of one item and advance the voice state
    function automatic walk_result_t predict_walk(input logic act, input logic [8:0] h,
                                                  input logic [31:0] rate,
                                                  input logic [16:0] amp_in,
                                                  input logic [31:0] sv);
        walk_result_t r;
        int v;
        longint sr, stp, bip, dlt, x, amp;
        r.sample = '0;
        r.ok = 1'b0;
        if (h < 1 || h > NVOICE)
            return r;
        v = h - 1;
        r.ok = 1'b1;
        if (act)
        begin
            seed_mem[v] = 32'd1;
            pos_mem[v]  = 32'd0;
            last_mem[v] = 32'd1;
            return r;
        end
        if (sv != last_mem[v])
        begin
            seed_mem[v] = (sv == 0) ? 32'd1 : sv;
            pos_mem[v]  = 32'd0;
            last_mem[v] = sv;
        end
        sr = (rate_hz == 0) ? 44100 : longint'(rate_hz);
        if (longint'(rate) >= 256 * sr)
            stp = 375809638;
        else
            stp = ((longint'(rate) * 7) <<< 22) / (20 * sr);
        seed_mem[v] = seed_mem[v] * 32'd1664525 + 32'd1013904223;
        bip = longint'(seed_mem[v]) - 64'sd2147483648;
        dlt = (bip * stp) >>> 31;
        x = longint'($signed(pos_mem[v])) + dlt;
        if (x > 64'sd1073741824)
            x = 64'sd2147483648 - x;
        if (x < -64'sd1073741824)
            x = -64'sd2147483648 - x;
        pos_mem[v] = x[31:0];
        amp = (amp_in > 17'd65536) ? 65536 : longint'(amp_in);
        x = (x * amp) >>> 16;
        r.sample = x[31:0];
        return r;
    endfunction

    // Track configuration, predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        walk_result_t got, exp_r;
        if (!rst_n)
        begin
            for (int i = 0; i < NVOICE; i++)
            begin
                seed_mem[i] = 32'd1;
                pos_mem[i]  = 32'd0;
                last_mem[i] = 32'd1;
            end
            rate_hz = 20'd44100;
            sample_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                sample_queue.push_back(predict_walk(in_ch.action, in_ch.voice_handle,
                                                    in_ch.rate_q8, in_ch.amplitude_q16,
                                                    in_ch.seed_value));
            if (out_ch.valid && out_ch.ready)
            begin
                got.sample = out_ch.walk_sample;
                got.ok = out_ch.handle_ok;
                if (sample_queue.size() == 0)
                    report_mismatch("result with no item outstanding");
                else
                begin
                    exp_r = sample_queue.pop_front();
                    if (got.sample !== exp_r.sample)
                        report_mismatch($sformatf("walk_sample %0d, predicted %0d",
                                                  got.sample, exp_r.sample));
                    if (got.ok !== exp_r.ok)
                        report_mismatch($sformatf("handle_ok %0b, predicted %0b",
                                                  got.ok, exp_r.ok));
                end
            end
            // register write lands after this edge's item
            if (cfg_we)
                rate_hz = cfg_wdata;
        end
    end

endmodule

/* tb/reflecting_lcg_random_walk_tb.sv */
`timescale 1ns / 100ps

module reflecting_lcg_random_walk_tb;
    import rlrw_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_we = 1'b0;
    logic [SR_W-1:0] cfg_wdata = '0;
    int              fail_count;
    int              pending_count;
    int              cycle_count = 0;
    bit              calm = 1'b0;

    rlrw_in_if  in_ch();
    rlrw_out_if out_ch();

    reflecting_lcg_random_walk uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    rlrw_walk_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_ch(in_ch), .out_ch(out_ch),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    always #5 clk = ~clk;

    // Stall the result side at random, except in calm stretches
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= calm || ($urandom_range(99) >= 34);
        end
    end

    // Hard stop
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one item and hold it until taken
    task automatic send_item(input logic act, input logic [8:0] h, input logic [31:0] rate,
                             input logic [16:0] amp, input logic [31:0] sv);
        do
            @(negedge clk);
        while (!calm && $urandom_range(99) < 34);
        in_ch.valid <= 1'b1;
        in_ch.action <= act;
        in_ch.voice_handle <= h;
        in_ch.rate_q8 <= rate;
        in_ch.amplitude_q16 <= amp;
        in_ch.seed_value <= sv;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    task automatic drain_results();
        while (pending_count != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_rate(input logic [SR_W-1:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly a few voices with steady seeds so walks develop; some noise
    task automatic random_item(input int voice_span);
        logic [31:0] rate;
        logic [31:0] sv;
        logic [8:0]  h;
        int pick;
        pick = $urandom_range(99);
        h = 9'($urandom_range(1, voice_span));
        sv = 32'($urandom_range(3));
        case ($urandom_range(3))
            0: rate = $urandom;
            1: rate = 32'($urandom_range(0, 256 * 48000));
            default: rate = 32'($urandom_range(0, 4000000));
        endcase
        if (pick < 4)
            send_item(1'b0, 9'($urandom_range(257, 511)), rate, 17'($urandom), $urandom);
        else if (pick < 7)
            send_item(1'b0, 9'd0, rate, 17'($urandom), $urandom);
        else if (pick < 11)
            send_item(1'b1, h, $urandom, 17'($urandom), $urandom);
        else if (pick < 15)
            send_item(1'b0, h, rate, 17'($urandom), $urandom);
        else
            send_item(1'b0, h, rate, 17'($urandom_range(0, 65536)), sv);
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        in_ch.voice_handle = '0;
        in_ch.rate_q8 = '0;
        in_ch.amplitude_q16 = '0;
        in_ch.seed_value = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, both actions, bad handles, seed changes
        send_item(1'b0, 9'd1, 32'd0, 17'd65536, 32'd1);
        send_item(1'b0, 9'd1, 32'hFFFF_FFFF, 17'd65536, 32'd1);
        send_item(1'b0, 9'd1, 32'hFFFF_FFFF, 17'h1FFFF, 32'd1);
        send_item(1'b0, 9'd256, 32'd11289600, 17'd0, 32'hFFFF_FFFF);
        send_item(1'b0, 9'd256, 32'd11289599, 17'd32768, 32'hFFFF_FFFF);
        send_item(1'b0, 9'd2, 32'd5000, 17'd65536, 32'd0);
        send_item(1'b0, 9'd2, 32'd5000, 17'd65536, 32'd0);
        send_item(1'b0, 9'd0, 32'd5000, 17'd65536, 32'd7);
        send_item(1'b0, 9'd257, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 9'd511, 32'd1, 17'd1, 32'd9);
        send_item(1'b1, 9'd256, 32'hFFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        send_item(1'b1, 9'd0, 32'd0, 17'd0, 32'd0);
        send_item(1'b1, 9'd300, 32'd0, 17'd0, 32'd0);
        repeat (8) send_item(1'b0, 9'd3, 32'hFFFF_FFFF, 17'd65536, 32'h5555_AAAA);
        send_item(1'b1, 9'd1, 32'd0, 17'd0, 32'd0);
        send_item(1'b0, 9'd1, 32'd100, 17'd65536, 32'd1);

        // Random phases over register settings, extremes included
        write_rate(20'd0);
        repeat (250) random_item(4);
        write_rate(20'd1);
        repeat (250) random_item(4);
        write_rate(20'hFFFFF);
        repeat (250) random_item(256);
        write_rate(20'd48000);
        calm = 1'b1;
        repeat (200) random_item(3);
        calm = 1'b0;
        // hold off until every result is back
        drain_results();
        repeat (250) random_item(8);
        write_rate(20'($urandom_range(1, 1048575)));
        repeat (200) random_item(2);
        write_rate(20'd44100);
        repeat (250) random_item(256);

        drain_results();
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
